[rtl/core/uafv_pkg.sv]
package uafv_pkg;

  // Sizes
  localparam int MAX_SAMPLES = 16;
  localparam int NUM_CH      = 4;
  localparam int NUM_SEG     = 5;
  localparam int GROUP_W     = 24;
  localparam int ROW_W       = GROUP_W * NUM_SEG;
  localparam int SLOT_W      = $clog2(MAX_SAMPLES);
  localparam int FILL_W      = $clog2(MAX_SAMPLES + 1);
  localparam int CH_W        = $clog2(NUM_CH);
  localparam int MEM_DEPTH   = NUM_CH * MAX_SAMPLES;
  localparam int MEM_AW      = CH_W + SLOT_W;

  // Frame codes
  localparam logic [7:0] LETTER_T   = 8'h74;
  localparam logic [7:0] LETTER_B   = 8'h62;
  localparam logic [7:0] LETTER_L   = 8'h6c;
  localparam logic [7:0] LETTER_R   = 8'h72;
  localparam logic [7:0] SEG_FIRST  = 8'h30;
  localparam logic [7:0] SEG_LAST   = 8'h34;
  localparam logic [GROUP_W-1:0] ZERO_GROUP = 24'h303030;
  localparam logic [4:0] FULL_MASK  = 5'h1f;
  localparam logic [4:0] MATCH_MAX  = 5'd31;

  // Register map
  localparam logic [2:0] REG_GROUP_A    = 3'd0;
  localparam logic [2:0] REG_GROUP_B    = 3'd1;
  localparam logic [2:0] REG_GROUP_C    = 3'd2;
  localparam logic [2:0] REG_GROUP_D    = 3'd3;
  localparam logic [2:0] REG_VOTE_COUNT = 3'd4;

  localparam logic [GROUP_W-1:0] RST_GROUP_A    = 24'h313535;
  localparam logic [GROUP_W-1:0] RST_GROUP_B    = 24'h313536;
  localparam logic [GROUP_W-1:0] RST_GROUP_C    = 24'h313537;
  localparam logic [GROUP_W-1:0] RST_GROUP_D    = 24'h313538;
  localparam logic [4:0]         RST_VOTE_COUNT = 5'd14;

  typedef struct packed {
    logic [GROUP_W-1:0] group_a;
    logic [GROUP_W-1:0] group_b;
    logic [GROUP_W-1:0] group_c;
    logic [GROUP_W-1:0] group_d;
    logic [4:0]         vote_count;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic ready;
    logic eval;
    logic store;
    logic aload;
    logic scan;
    logic tally;
    logic fetch;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic reach;
    logic b_last;
    logic a_last;
    logic out_free;
  } sts_t;

endpackage

[rtl/core/uafv_ctrl.sv]
module uafv_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           frame_accept,
  input  uafv_pkg::sts_t sts,
  output uafv_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_STORE, S_ALOAD, S_SCAN, S_TALLY, S_FETCH, S_EMIT
  } state_t;

  state_t state;

  // Sequence frames and the vote
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:  if (frame_accept) state <= S_EVAL;
        S_EVAL:  state <= sts.full ? S_STORE : S_IDLE;
        S_STORE: state <= sts.reach ? S_ALOAD : S_IDLE;
        S_ALOAD: state <= S_SCAN;
        S_SCAN:  if (sts.b_last) state <= S_TALLY;
        S_TALLY: state <= sts.a_last ? S_FETCH : S_ALOAD;
        S_FETCH: state <= S_EMIT;
        S_EMIT:  if (sts.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Decode commands
  always_comb begin
    cmd       = '0;
    cmd.ready = (state == S_IDLE);
    cmd.eval  = (state == S_EVAL);
    cmd.store = (state == S_STORE);
    cmd.aload = (state == S_ALOAD);
    cmd.scan  = (state == S_SCAN);
    cmd.tally = (state == S_TALLY);
    cmd.fetch = (state == S_FETCH);
    cmd.emit  = (state == S_EMIT);
  end

endmodule

[rtl/core/uafv_dp.sv]
module uafv_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  uafv_pkg::cfg_t                cfg,
  input  logic                          frame_accept,
  input  logic [7:0]                    direction_byte,
  input  logic [7:0]                    segment_byte,
  input  logic [7:0]                    digit_first,
  input  logic [7:0]                    digit_second,
  input  logic [7:0]                    digit_third,
  input  uafv_pkg::cmd_t                cmd,
  output uafv_pkg::sts_t                sts,
  input  logic                          result_stall,
  output logic                          result_valid,
  output logic [1:0]                    channel_code,
  output logic [uafv_pkg::GROUP_W-1:0]  group_zero,
  output logic [uafv_pkg::GROUP_W-1:0]  group_one,
  output logic [uafv_pkg::GROUP_W-1:0]  group_two,
  output logic [uafv_pkg::GROUP_W-1:0]  group_three,
  output logic [uafv_pkg::GROUP_W-1:0]  group_four,
  output logic [4:0]                    winner_matches
);

  localparam int GW = uafv_pkg::GROUP_W;
  localparam int SW = uafv_pkg::SLOT_W;
  localparam int FW = uafv_pkg::FILL_W;
  localparam int CW = uafv_pkg::CH_W;

  // Latched frame
  logic [7:0]    dir_q;
  logic [7:0]    seg_q;
  logic [GW-1:0] grp_q;

  // Assembly, masks, fill counts
  logic [GW-1:0] agrp [uafv_pkg::NUM_CH][uafv_pkg::NUM_SEG];
  logic [4:0]    mask [uafv_pkg::NUM_CH];
  logic [FW-1:0] fill [uafv_pkg::NUM_CH];

  // Sample memory
  logic [uafv_pkg::ROW_W-1:0] smem [uafv_pkg::MEM_DEPTH];
  logic [uafv_pkg::ROW_W-1:0] rd_a;
  logic [uafv_pkg::ROW_W-1:0] rd_b;

  // Vote registers
  logic [FW-1:0] vote_n;
  logic [SW-1:0] a_idx;
  logic [SW-1:0] b_idx;
  logic [SW-1:0] best;
  logic [FW-1:0] cnt;
  logic [FW-1:0] best_cnt;
  logic          pend;

  logic [CW-1:0] ch;
  logic          ch_ok;
  logic          seg_ok;
  logic [7:0]    seg_diff;
  logic [2:0]    seg;
  logic          grp_ok;
  logic          frame_ok;
  logic [4:0]    mask_base;
  logic [4:0]    mask_new;
  logic [SW-1:0] slot;
  logic [FW-1:0] fill_inc;
  logic [FW-1:0] lim;
  logic [SW-1:0] n_last;
  logic          match;
  logic [FW-1:0] cnt_fin;
  logic [SW-1:0] addr_a_slot;

  // Decode the latched frame
  always_comb begin
    ch_ok = 1'b1;
    ch    = '0;
    case (dir_q)
      uafv_pkg::LETTER_T: ch = CW'(0);
      uafv_pkg::LETTER_B: ch = CW'(1);
      uafv_pkg::LETTER_L: ch = CW'(2);
      uafv_pkg::LETTER_R: ch = CW'(3);
      default:            ch_ok = 1'b0;
    endcase
  end

  assign seg_ok   = (seg_q >= uafv_pkg::SEG_FIRST) && (seg_q <= uafv_pkg::SEG_LAST);
  assign seg_diff = seg_q - uafv_pkg::SEG_FIRST;
  assign seg      = seg_diff[2:0];
  assign grp_ok   = (grp_q == uafv_pkg::ZERO_GROUP) || (grp_q == cfg.group_a) ||
                    (grp_q == cfg.group_b) || (grp_q == cfg.group_c) ||
                    (grp_q == cfg.group_d);
  assign frame_ok  = ch_ok && seg_ok && grp_ok;
  assign mask_base = (seg == 3'd0) ? 5'd0 : mask[ch];
  assign mask_new  = mask_base | (5'b10000 >> seg);

  // Store slot and vote threshold
  assign slot = (fill[ch] >= FW'(uafv_pkg::MAX_SAMPLES)) ? SW'(uafv_pkg::MAX_SAMPLES - 1)
                                                           : fill[ch][SW-1:0];
  assign fill_inc = FW'(slot) + FW'(1);

  always_comb begin
    if (cfg.vote_count == 5'd0) begin
      lim = FW'(1);
    end else if (int'(cfg.vote_count) > uafv_pkg::MAX_SAMPLES) begin
      lim = FW'(uafv_pkg::MAX_SAMPLES);
    end else begin
      lim = FW'(cfg.vote_count);
    end
  end

  // Pairwise compare
  assign n_last      = SW'(vote_n - FW'(1));
  assign match       = pend && (rd_a == rd_b);
  assign cnt_fin     = cnt + FW'(match);
  assign addr_a_slot = (cmd.fetch || cmd.emit) ? best : a_idx;

  assign sts.full     = frame_ok && (mask_new == uafv_pkg::FULL_MASK);
  assign sts.reach    = fill_inc >= lim;
  assign sts.b_last   = (b_idx == n_last);
  assign sts.a_last   = (a_idx == n_last);
  assign sts.out_free = !result_valid || !result_stall;

  // Hold the frame
  always_ff @(posedge clk) begin
    if (frame_accept) begin
      dir_q <= direction_byte;
      seg_q <= segment_byte;
      grp_q <= {digit_first, digit_second, digit_third};
    end
  end

  // Assemble address groups
  always_ff @(posedge clk) begin
    if (cmd.eval && frame_ok) begin
      agrp[ch][seg] <= grp_q;
    end
  end

  // Update masks and fill counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < uafv_pkg::NUM_CH; k++) begin
        mask[k] <= '0;
        fill[k] <= '0;
      end
    end else begin
      if (cmd.eval && frame_ok) begin
        mask[ch] <= mask_new;
      end
      if (cmd.store) begin
        fill[ch] <= fill_inc;
      end else if (cmd.emit && sts.out_free) begin
        fill[ch] <= '0;
      end
    end
  end

  // Write samples
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      smem[{ch, slot}] <= {agrp[ch][0], agrp[ch][1], agrp[ch][2], agrp[ch][3], agrp[ch][4]};
    end
  end

  // Read samples on two ports
  always_ff @(posedge clk) begin
    rd_a <= smem[{ch, addr_a_slot}];
    rd_b <= smem[{ch, b_idx}];
  end

  // Advance the vote
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      vote_n   <= fill_inc;
      a_idx    <= '0;
      best     <= '0;
      best_cnt <= '0;
    end
    if (cmd.aload) begin
      b_idx <= '0;
      cnt   <= '0;
    end
    if (cmd.scan) begin
      b_idx <= b_idx + SW'(1);
      cnt   <= cnt_fin;
    end
    if (cmd.tally) begin
      a_idx <= a_idx + SW'(1);
      if (cnt_fin > best_cnt) begin
        best_cnt <= cnt_fin;
        best     <= a_idx;
      end
    end
  end

  // Hand the winner to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit && sts.out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && sts.out_free) begin
      channel_code   <= 2'(ch);
      group_zero     <= rd_a[5*GW-1:4*GW];
      group_one      <= rd_a[4*GW-1:3*GW];
      group_two      <= rd_a[3*GW-1:2*GW];
      group_three    <= rd_a[2*GW-1:GW];
      group_four     <= rd_a[GW-1:0];
      winner_matches <= (int'(best_cnt) > int'(uafv_pkg::MATCH_MAX)) ? uafv_pkg::MATCH_MAX
                                                                     : 5'(best_cnt);
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (fill[0] <= FW'(uafv_pkg::MAX_SAMPLES)) && (fill[1] <= FW'(uafv_pkg::MAX_SAMPLES)) &&
    (fill[2] <= FW'(uafv_pkg::MAX_SAMPLES)) && (fill[3] <= FW'(uafv_pkg::MAX_SAMPLES)))
    else $error("fill count above sample depth");
  a_winner_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (best_cnt != '0))
    else $error("vote ended without a match");
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> (FW'(b_idx) < vote_n))
    else $error("scan index past filled samples");
  a_store_full: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> (mask[ch] == uafv_pkg::FULL_MASK))
    else $error("store without a complete address");
`endif

endmodule

[rtl/core/uart_address_frame_voter.sv]
// Channel   Handshake                 Payload
// frame     frame_valid/frame_stall   direction_byte, segment_byte, digit_first..third
// result    result_valid/result_stall channel_code, group_zero..four, winner_matches
// config    APB (psel/penable)        paddr, pwdata, prdata
//
// A frame passes through an evaluate state; one that completes an address is also stored.
// A vote over n samples, started once a store reaches the vote count, runs a pairwise
// compare loop on the two read ports of the sample memory, then fetches and emits the winner.
// Reset clears masks, fill counts and result_valid; stores start undefined.
// A stalled result holds; frames stall while a vote runs and until its result is emitted.
module uart_address_frame_voter (
  input  logic        clk,
  input  logic        rst,
  input  logic        frame_valid,
  output logic        frame_stall,
  input  logic [7:0]  direction_byte,
  input  logic [7:0]  segment_byte,
  input  logic [7:0]  digit_first,
  input  logic [7:0]  digit_second,
  input  logic [7:0]  digit_third,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  channel_code,
  output logic [23:0] group_zero,
  output logic [23:0] group_one,
  output logic [23:0] group_two,
  output logic [23:0] group_three,
  output logic [23:0] group_four,
  output logic [4:0]  winner_matches,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  uafv_pkg::cfg_t cfg;
  uafv_pkg::cmd_t cmd;
  uafv_pkg::sts_t sts;
  logic           frame_accept;
  logic           cfg_write;
  logic [2:0]     reg_idx;

  assign pready       = 1'b1;
  assign cfg_write    = psel && penable && pwrite && pready;
  assign reg_idx      = paddr[4:2];
  assign frame_stall  = !cmd.ready;
  assign frame_accept = frame_valid && !frame_stall;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.group_a    <= uafv_pkg::RST_GROUP_A;
      cfg.group_b    <= uafv_pkg::RST_GROUP_B;
      cfg.group_c    <= uafv_pkg::RST_GROUP_C;
      cfg.group_d    <= uafv_pkg::RST_GROUP_D;
      cfg.vote_count <= uafv_pkg::RST_VOTE_COUNT;
    end else if (cfg_write) begin
      case (reg_idx)
        uafv_pkg::REG_GROUP_A:    cfg.group_a    <= pwdata[23:0];
        uafv_pkg::REG_GROUP_B:    cfg.group_b    <= pwdata[23:0];
        uafv_pkg::REG_GROUP_C:    cfg.group_c    <= pwdata[23:0];
        uafv_pkg::REG_GROUP_D:    cfg.group_d    <= pwdata[23:0];
        uafv_pkg::REG_VOTE_COUNT: cfg.vote_count <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Read back configuration
  always_comb begin
    case (reg_idx)
      uafv_pkg::REG_GROUP_A:    prdata = {8'd0, cfg.group_a};
      uafv_pkg::REG_GROUP_B:    prdata = {8'd0, cfg.group_b};
      uafv_pkg::REG_GROUP_C:    prdata = {8'd0, cfg.group_c};
      uafv_pkg::REG_GROUP_D:    prdata = {8'd0, cfg.group_d};
      uafv_pkg::REG_VOTE_COUNT: prdata = {27'd0, cfg.vote_count};
      default:                  prdata = '0;
    endcase
  end

  uafv_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .frame_accept (frame_accept),
    .sts          (sts),
    .cmd          (cmd)
  );

  uafv_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .frame_accept   (frame_accept),
    .direction_byte (direction_byte),
    .segment_byte   (segment_byte),
    .digit_first    (digit_first),
    .digit_second   (digit_second),
    .digit_third    (digit_third),
    .cmd            (cmd),
    .sts            (sts),
    .result_stall   (result_stall),
    .result_valid   (result_valid),
    .channel_code   (channel_code),
    .group_zero     (group_zero),
    .group_one      (group_one),
    .group_two      (group_two),
    .group_three    (group_three),
    .group_four     (group_four),
    .winner_matches (winner_matches)
  );

endmodule
